// ===== rtl/shuffled_minimal_standard_rng_defines.svh =====
// Assertion macros shared by the generator RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SHUFFLED_MINIMAL_STANDARD_RNG_DEFINES_SVH
`define SHUFFLED_MINIMAL_STANDARD_RNG_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SRNG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srng: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define SRNG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srng: next-cycle check failed");

`endif

// ===== rtl/srng_pkg.sv =====
// Constants and types for the shuffled minimal-standard generator.
// No dependencies; imported by srng_lehmer, the top level and the testbench.
package srng_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int WARMUP_EXTRA  = 8;
    localparam int SEED_STEPS    = TABLE_ENTRIES + WARMUP_EXTRA;

    localparam int VAL_W  = 31;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(SEED_STEPS + 1);
    localparam int ADDR_W = 2;
    localparam int DATA_W = 32;

    localparam logic [14:0]      LEHMER_MUL  = 15'd16807;
    localparam logic [VAL_W-1:0] LEHMER_MOD  = 31'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] CLAMP_LIMIT = 31'd2147483390;

    // Slot divisor 1 + (2^31 - 2) / TABLE_ENTRIES, a power of two for the table sizes used
    localparam longint SLOT_DIV   = 64'd1 + (64'd2147483646 / TABLE_ENTRIES);
    localparam int     SLOT_SHIFT = $clog2(SLOT_DIV);

    localparam logic [ADDR_W-1:0] ADDR_SEED = 2'd0;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SEED = 4'b0010,
        ST_READ = 4'b0100,
        ST_PICK = 4'b1000
    } t_state;

endpackage

// ===== rtl/srng_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for the shuffle table.
module srng_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/srng_lehmer.sv =====
// One Lehmer step x * 16807 mod (2^31 - 1), folded with the Mersenne identity.
// Depends on srng_pkg.
module srng_lehmer
    import srng_pkg::*;
(
    input  logic [VAL_W-1:0] i_x,
    output logic [VAL_W-1:0] o_x
);

    logic [VAL_W+14:0] w_prod;
    logic [VAL_W:0]    w_sum;
    logic [VAL_W:0]    w_red;

    always_comb begin
        w_prod = i_x * LEHMER_MUL;
        // 2^31 == 1 mod M: add the high part back onto the low part
        w_sum  = {1'b0, w_prod[VAL_W-1:0]} + {17'd0, w_prod[VAL_W+14:VAL_W]};
        w_red  = w_sum - {1'b0, LEHMER_MOD};
        o_x    = (w_sum >= {1'b0, LEHMER_MOD}) ? w_red[VAL_W-1:0] : w_sum[VAL_W-1:0];
    end

endmodule

// ===== rtl/shuffled_minimal_standard_rng.sv =====
// Shuffled minimal-standard uniform generator, top level.
// Depends on srng_pkg, srng_lehmer, srng_ram and the defines header.
//
// Usage:
//   Slave stream: each item carries range_low and range_high and requests one
//   sample. Master stream: one item per request with raw_value and
//   scaled_value = range_low + floor((range_high - range_low) * u / 2^31),
//   u being raw_value clamped at 2147483390.
//   APB port: register 0 (address 0) is the 31-bit seed; a write makes the
//   next request reseed. pready is always high.
// Flow: a request is taken only in the idle state; its table read (slot from the
//   previous pick) is followed by its write-back in the pick state, with tready
//   low until then. A request that reseeds first runs the seed state, one Lehmer
//   step per cycle while the last 32 states fill the table, then the read state.
//   Each sample then passes the clamp, multiply and output registers.
// Reset: seed 1, generator flagged for reseeding; the table is not cleared,
//   the first request fills it before any entry is read.
// Stall: a result waits in the output register; the multiply and pick stages
//   behind it keep going until full, then input tready stays low.
`include "shuffled_minimal_standard_rng_defines.svh"

module shuffled_minimal_standard_rng
    import srng_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // range_low [31:0], range_high [63:32]
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,
    // raw_value [30:0], scaled_value [62:31], zero [63]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [63:0]       m_axis_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_state                  r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [VAL_W-1:0]        r_seed;
    logic                    r_need_seed;
    logic [VAL_W-1:0]        r_lehmer;
    logic [VAL_W-1:0]        r_last_pick;
    logic [IDX_W-1:0]        r_slot;
    logic signed [31:0]      r_low;
    logic signed [32:0]      r_span;

    logic                    r_v1;
    logic [VAL_W-1:0]        r_u1;
    logic [VAL_W-1:0]        r_raw1;
    logic signed [32:0]      r_span1;
    logic signed [31:0]      r_low1;

    logic                    r_v2;
    logic signed [63:0]      r_prod2;
    logic [VAL_W-1:0]        r_raw2;
    logic signed [31:0]      r_low2;

    logic                    r_out_valid;
    logic [VAL_W-1:0]        r_out_raw;
    logic [31:0]             r_out_scaled;

    logic                    w_accept;
    logic                    w_cfg_wr;
    logic                    w_seed_cond;
    logic [VAL_W-1:0]        w_lehmer_next;
    logic [VAL_W-1:0]        w_slot_full;
    logic [IDX_W-1:0]        w_slot;
    logic [CNT_W-1:0]        w_seed_idx;
    logic                    w_seed_last;
    logic                    w_free1;
    logic                    w_free2;
    logic                    w_free3;
    logic                    w_adv1;
    logic                    w_adv2;
    logic                    w_load1;
    logic signed [32:0]      w_span;
    logic signed [64:0]      w_prod;
    logic [VAL_W-1:0]        w_clamped;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [VAL_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [VAL_W-1:0]        ram_rdata;

    srng_lehmer u_lehmer (
        .i_x (r_lehmer),
        .o_x (w_lehmer_next)
    );

    srng_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (w_slot),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr      = psel && penable && pwrite && (paddr == ADDR_SEED);
    assign w_seed_cond   = r_need_seed || (r_last_pick == '0);

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SEED) ? {1'b0, r_seed} : '0;

    // Slot select from the previous pick, clamped to the table
    always_comb begin
        w_slot_full = r_last_pick >> SLOT_SHIFT;
        if (w_slot_full >= VAL_W'(TABLE_ENTRIES)) begin
            w_slot = IDX_W'(TABLE_ENTRIES - 1);
        end else begin
            w_slot = w_slot_full[IDX_W-1:0];
        end
    end

    assign w_seed_idx  = CNT_W'(SEED_STEPS - 1) - r_cnt;
    assign w_seed_last = (r_cnt == CNT_W'(SEED_STEPS - 1));

    assign w_free3 = !r_out_valid || m_axis_tready;
    assign w_adv2  = r_v2 && w_free3;
    assign w_free2 = !r_v2 || w_free3;
    assign w_adv1  = r_v1 && w_free2;
    assign w_free1 = !r_v1 || w_free2;
    assign w_load1 = (r_state == ST_PICK) && w_free1;

    assign w_span    = {s_axis_tdata[63], s_axis_tdata[63:32]}
                     - {s_axis_tdata[31], s_axis_tdata[31:0]};
    assign w_clamped = (ram_rdata > CLAMP_LIMIT) ? CLAMP_LIMIT : ram_rdata;
    assign w_prod    = r_span1 * $signed({1'b0, r_u1});

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = w_lehmer_next;
        ram_re    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                ram_re = w_accept && !w_seed_cond;
            end
            ST_SEED: begin
                // keep only the last TABLE_ENTRIES states, top slot first
                ram_we    = (w_seed_idx < CNT_W'(TABLE_ENTRIES));
                ram_waddr = w_seed_idx[IDX_W-1:0];
            end
            ST_READ: begin
                ram_re = 1'b1;
            end
            ST_PICK: begin
                ram_we = w_free1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_seed      <= VAL_W'(1);
            r_need_seed <= 1'b1;
            r_lehmer    <= VAL_W'(1);
            r_last_pick <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (w_seed_cond) begin
                            r_lehmer <= (r_seed == '0) ? VAL_W'(1) : r_seed;
                            r_cnt    <= '0;
                            r_state  <= ST_SEED;
                        end else begin
                            r_state  <= ST_PICK;
                        end
                    end
                end
                ST_SEED: begin
                    r_lehmer <= w_lehmer_next;
                    if (w_seed_last) begin
                        r_last_pick <= w_lehmer_next;
                        r_need_seed <= 1'b0;
                        r_state     <= ST_READ;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_READ: begin
                    r_state <= ST_PICK;
                end
                ST_PICK: begin
                    // hold the read data until the pick stage frees up
                    if (w_free1) begin
                        r_lehmer    <= w_lehmer_next;
                        r_last_pick <= ram_rdata;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_cfg_wr) begin
                r_seed      <= pwdata[VAL_W-1:0];
                r_need_seed <= 1'b1;
            end
        end
    end

    // Request payload and slot of the pending read
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_low  <= s_axis_tdata[31:0];
            r_span <= w_span;
        end
        if (ram_re) begin
            r_slot <= w_slot;
        end
    end

    // Clamp, multiply and offset stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1        <= w_load1 || (r_v1 && !w_adv1);
            r_v2        <= w_adv1 || (r_v2 && !w_adv2);
            r_out_valid <= w_adv2 || (r_out_valid && !m_axis_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load1) begin
            r_u1    <= w_clamped;
            r_raw1  <= ram_rdata;
            r_span1 <= r_span;
            r_low1  <= r_low;
        end
        if (w_adv1) begin
            r_prod2 <= w_prod[63:0];
            r_raw2  <= r_raw1;
            r_low2  <= r_low1;
        end
        if (w_adv2) begin
            r_out_raw    <= r_raw2;
            // arithmetic shift of the product floors toward minus infinity
            r_out_scaled <= r_low2 + r_prod2[62:31];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_scaled, r_out_raw};

    `SRNG_ASSERT_NOW(a_no_rw_overlap, i_clk, i_rst_n, ram_we, !ram_re)
    `SRNG_ASSERT_NEXT(a_seed_done, i_clk, i_rst_n,
        (r_state == ST_SEED) && w_seed_last && !w_cfg_wr,
        !r_need_seed && (r_state == ST_READ))
    `SRNG_ASSERT_NEXT(a_pick_loads, i_clk, i_rst_n, w_load1, r_v1 && (r_state == ST_IDLE))
    `SRNG_ASSERT_NOW(a_pick_has_read, i_clk, i_rst_n,
        (r_state == ST_PICK), !ram_re && !s_axis_tready)

endmodule

// ===== tb/shuffled_minimal_standard_rng_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for shuffled_minimal_standard_rng: drives range items and
// seed writes, predicts each sample with its own Lehmer/shuffle model and checks it.
// Depends on srng_pkg and the generator RTL only.
module shuffled_minimal_standard_rng_tb;
    import srng_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [VAL_W-1:0]   raw_value;
        logic signed [31:0] scaled_value;
    } t_draw;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [63:0]       m_axis_tdata;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [DATA_W-1:0] pwdata        = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Predictor state
    logic [VAL_W-1:0] seed_reg;
    logic [VAL_W-1:0] gen_state;
    logic [VAL_W-1:0] shuffle_mem [TABLE_ENTRIES];
    logic [VAL_W-1:0] last_draw;
    logic             reseed_pending;

    logic [63:0] range_pending [$];
    t_draw       expected_draws [$];
    t_draw       want;

    int  fail_count = 0;
    int  idle_odds  = 0;
    bit  quiet_tail = 1'b0;
    int  src_gap    = 0;
    int  sink_gap   = 0;
    int  idle_count = 0;

    shuffled_minimal_standard_rng u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [VAL_W-1:0] lehmer_advance(input logic [VAL_W-1:0] x);
        logic [63:0] prod;
        prod = 64'(x) * 64'(LEHMER_MUL);
        return VAL_W'(prod % 64'(LEHMER_MOD));
    endfunction

    // Run the warm-up steps and fill the table from the top slot down.
    function automatic void refill_shuffle();
        gen_state = (seed_reg == '0) ? VAL_W'(1) : seed_reg;
        for (int i = SEED_STEPS - 1; i >= 0; i--) begin
            gen_state = lehmer_advance(gen_state);
            if (i < TABLE_ENTRIES)
                shuffle_mem[i] = gen_state;
        end
        last_draw      = shuffle_mem[0];
        reseed_pending = 1'b0;
    endfunction

    function automatic void predict_draw(input logic signed [31:0] low,
                                         input logic signed [31:0] high);
        longint           slot;
        logic [VAL_W-1:0] frac;
        longint           span;
        longint           prod;
        t_draw            d;
        if (reseed_pending || last_draw == '0)
            refill_shuffle();
        gen_state = lehmer_advance(gen_state);
        slot = longint'({1'b0, last_draw}) >> SLOT_SHIFT;
        if (slot >= TABLE_ENTRIES)
            slot = TABLE_ENTRIES - 1;
        last_draw         = shuffle_mem[slot];
        shuffle_mem[slot] = gen_state;
        frac = (last_draw > CLAMP_LIMIT) ? CLAMP_LIMIT : last_draw;
        span = longint'(high) - longint'(low);
        prod = span * longint'({1'b0, frac});
        // arithmetic shift floors toward minus infinity for reversed ranges
        d.raw_value    = last_draw;
        d.scaled_value = 32'(longint'(low) + (prod >>> 31));
        expected_draws.push_back(d);
    endfunction

    function automatic void note_failure(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("mismatch: %s", msg);
        fail_count++;
    endfunction

    function automatic void push_range(input logic signed [31:0] low,
                                       input logic signed [31:0] high);
        range_pending.push_back({high, low});
    endfunction

    function automatic void push_random_range();
        logic signed [31:0] low;
        logic signed [31:0] high;
        logic [31:0]        corner [4];
        corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        low  = $urandom;
        high = $urandom;
        case ($urandom_range(0, 9))
            5, 6: high = low + $urandom_range(0, 1000);
            7:    high = low - $urandom_range(1, 1000);
            8:    high = low;
            9: begin
                low  = corner[$urandom_range(0, 3)];
                high = corner[$urandom_range(0, 3)];
            end
            default: ;
        endcase
        push_range(low, high);
    endfunction

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (range_pending.size() != 0 || s_axis_tvalid || expected_draws.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [VAL_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SEED;
        pwdata  <= {1'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        seed_reg       = value;
        reseed_pending = 1'b1;
    endtask

    // Sender: hold each item until accepted, idle in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_draw(s_axis_tdata[31:0], s_axis_tdata[63:32]);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (range_pending.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= range_pending.pop_front();
                    if (!quiet_tail && $urandom_range(0, 9) < idle_odds)
                        src_gap = $urandom_range(1, 9);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: compare each sample with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_draws.size() == 0) begin
                    note_failure($sformatf("unexpected sample raw %0d scaled %0d",
                                           m_axis_tdata[30:0], $signed(m_axis_tdata[62:31])));
                end else begin
                    want = expected_draws.pop_front();
                    if (m_axis_tdata[30:0] !== want.raw_value
                        || m_axis_tdata[62:31] !== want.scaled_value
                        || m_axis_tdata[63] !== 1'b0)
                        note_failure($sformatf("raw exp %0d got %0d, scaled exp %0d got %0d, pad %b",
                                               want.raw_value, m_axis_tdata[30:0],
                                               want.scaled_value, $signed(m_axis_tdata[62:31]),
                                               m_axis_tdata[63]));
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 9) < idle_odds)
                    sink_gap = $urandom_range(1, 9);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [VAL_W-1:0] phase_seed;
        int               phase_items;
        seed_reg       = VAL_W'(1);
        gen_state      = VAL_W'(1);
        last_draw      = '0;
        reseed_pending = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset seed: range extremes, reversed and empty ranges.
        idle_odds = 3;
        push_range(32'sd0, 32'sd0);
        push_range(32'sh8000_0000, 32'sh7FFF_FFFF);
        push_range(32'sh7FFF_FFFF, 32'sh8000_0000);
        push_range(32'sh8000_0000, 32'sh8000_0000);
        push_range(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_range(-32'sd1, 32'sd0);
        push_range(32'sd0, -32'sd1);
        push_range(32'sd0, 32'sd1);
        push_range(-32'sd5, 32'sd5);
        push_range(32'sd5, -32'sd5);
        // drain once mid-stream with no register write
        wait_drained();
        push_range(32'sh8000_0000, 32'sd0);
        push_range(32'sd0, 32'sh7FFF_FFFF);
        push_range(32'sh7FFF_FFFF, 32'sd0);
        push_range(32'sd0, 32'sh8000_0000);
        push_range(32'sh5555_5555, 32'shAAAA_AAAA);
        push_range(32'shAAAA_AAAA, 32'sh5555_5555);
        push_range(-32'sd1000, 32'sd1000);
        push_range(32'sd100, 32'sd99);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       phase_seed = '0;
                1:       phase_seed = LEHMER_MOD;
                2:       phase_seed = LEHMER_MOD - 1;
                default: phase_seed = VAL_W'($urandom);
            endcase
            phase_items = (p == 1) ? 20 : (p < 3) ? 150 : 200;
            idle_odds   = $urandom_range(0, 5);
            quiet_tail  = (p == 7);
            write_seed(phase_seed);
            repeat (phase_items) push_random_range();
            wait_drained();
        end

        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_draws.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
